### rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by the cache top level and the bench.
`timescale 1ns / 1ps

package lkv_pkg;

    // Field widths fixed by the request and result format
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_COMMIT = 2'd3
    } state_t;

endpackage

### rtl/lkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the key/value store of the cache.
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg and lkv_ram (key/value store).
//
// A request runs through the scan, drain and commit states; the result is registered
// after the commit. busy holds from the scan through the commit, so a new request is taken
// only once idle; the scan reads one entry a cycle through the single key comparator.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears valid bits, ranks, the live count and sets
// the capacity to 16; the RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  store_value,
    // Result strobe
    output logic                              done,
    output logic                              found,
    output logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    output logic                              evicted,
    output logic signed [lkv_pkg::KEY_W-1:0]  evicted_key,
    // Capacity register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         cfg_data
);

    import lkv_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = KEY_W + VAL_W;

    // Sequencer and request registers
    state_t                  state_reg, state_next;
    cmd_t                    req_cmd_reg;
    logic [KEY_W-1:0]        req_key_reg;
    logic [VAL_W-1:0]        req_val_reg;
    logic [CAP_W-1:0]        cap_reg;

    // Per-entry status
    logic [ENTRIES-1:0]      valid_reg;
    logic [RANK_W-1:0]       rank_reg [ENTRIES];
    logic [CNT_W-1:0]        live_reg;

    // Scan bookkeeping
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    cmp_valid_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_slot_reg;
    logic [RANK_W-1:0]       hit_rank_reg;
    logic [VAL_W-1:0]        hit_val_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_slot_reg;
    logic [IDX_W-1:0]        victim_slot_reg;
    logic [KEY_W-1:0]        victim_key_reg;

    // Result registers
    logic                    done_reg;
    logic                    found_reg;
    logic [VAL_W-1:0]        read_value_reg;
    logic                    evicted_reg;
    logic [KEY_W-1:0]        evicted_key_reg;

    // Control decoded from the state
    logic                    accept;
    logic                    scanning;
    logic                    comparing;
    logic                    committing;

    // RAM ports
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [WORD_W-1:0]       ram_wr_data;
    logic [WORD_W-1:0]       ram_rd_data;
    logic [KEY_W-1:0]        rd_key;
    logic [VAL_W-1:0]        rd_val;

    // Commit decisions
    logic [CMP_W-1:0]        cap_ext;
    logic [CMP_W-1:0]        eff_cap;
    logic                    full;
    logic [RANK_W-1:0]       victim_rank;
    logic                    do_insert;
    logic                    do_evict;
    logic                    do_update;
    logic [IDX_W-1:0]        commit_slot;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        scanning   = 1'b0;
        comparing  = 1'b0;
        committing = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                scanning  = 1'b1;
                comparing = cmp_valid_reg;
            end
            ST_DRAIN:
            begin
                comparing = cmp_valid_reg;
            end
            ST_COMMIT:
            begin
                committing = 1'b1;
            end
            default:
            begin
                scanning   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Hold the request for the length of the operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_cmd_reg <= cmd_t'(cmd);
            req_key_reg <= lookup_key;
            req_val_reg <= store_value;
        end
    end

    // Clamp capacity to 1 .. ENTRIES and decide whether an insert must evict
    assign cap_ext     = CMP_W'(cap_reg);
    assign eff_cap     = (cap_ext == '0) ? CMP_W'(1) :
                         ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
    assign full        = (CMP_W'(live_reg) >= eff_cap);
    assign victim_rank = RANK_W'(live_reg - CNT_W'(1));

    assign {rd_key, rd_val} = ram_rd_data;

    // Advance the scan address; the compare stage works on it in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= scanning;
            cmp_idx_reg   <= scan_idx_reg;
            if (accept)
            begin
                scan_idx_reg <= '0;
            end
            else if (scanning)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    // Shared comparator: match key, spot the least recent entry and the first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (accept)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (comparing)
        begin
            if (valid_reg[cmp_idx_reg] && (rd_key == req_key_reg))
            begin
                hit_reg <= 1'b1;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (comparing)
        begin
            if (valid_reg[cmp_idx_reg] && (rd_key == req_key_reg))
            begin
                hit_slot_reg <= cmp_idx_reg;
                hit_rank_reg <= rank_reg[cmp_idx_reg];
                hit_val_reg  <= rd_val;
            end
            if (valid_reg[cmp_idx_reg] && (rank_reg[cmp_idx_reg] == victim_rank))
            begin
                victim_slot_reg <= cmp_idx_reg;
                victim_key_reg  <= rd_key;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_slot_reg <= cmp_idx_reg;
            end
        end
    end

    // Decide the commit action
    assign do_insert   = committing && !hit_reg && (req_cmd_reg == CMD_PUT);
    assign do_evict    = do_insert && full;
    assign do_update   = committing && hit_reg;
    assign commit_slot = hit_reg ? hit_slot_reg :
                         (full ? victim_slot_reg : free_slot_reg);

    assign ram_wr_en   = do_insert || (do_update && (req_cmd_reg == CMD_PUT));
    assign ram_wr_addr = commit_slot;
    assign ram_wr_data = {req_key_reg, req_val_reg};

    // Update valid bits, recency ranks and the live count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            live_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (do_insert || do_update)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_W'(i) == commit_slot)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (do_insert || (rank_reg[i] < hit_rank_reg)))
                begin
                    rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                end
            end
            if (do_insert)
            begin
                valid_reg[commit_slot] <= 1'b1;
                if (!full)
                begin
                    live_reg <= live_reg + CNT_W'(1);
                end
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= committing;
        end
    end

    always_ff @(posedge clk)
    begin
        if (committing)
        begin
            found_reg       <= hit_reg;
            read_value_reg  <= (hit_reg && (req_cmd_reg == CMD_GET)) ? hit_val_reg : '0;
            evicted_reg     <= do_evict;
            evicted_key_reg <= do_evict ? victim_key_reg : '0;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // Key/value store
    lkv_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    // Live count tracks the valid bits
    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(live_reg))
        else $error("live count out of step with valid bits");

    // A result is strobed only after a commit
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_COMMIT))
        else $error("result strobe without commit");

    // An accepted request makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // An eviction never reports a found key
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> !found)
        else $error("eviction reported on a hit");

endmodule

### bench/tb.sv
// Self-checking bench for lru_key_value_cache: queued get/put requests, clocked driver and monitor.
// Depends on lkv_pkg and the cache RTL; expected results come from a behavioural LRU store below.
`timescale 1ns / 1ps

module tb;

    import lkv_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int CYC_LIMIT = 300000;
    localparam int PHASE_LEN = 135;

    typedef struct
    {
        cmd_t             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        int unsigned      gap;
    } cache_req_t;

    typedef struct
    {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_resp_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs, known from time zero
    logic                    start       = 1'b0;
    logic                    cmd         = 1'b0;
    logic signed [KEY_W-1:0] lookup_key  = '0;
    logic signed [VAL_W-1:0] store_value = '0;
    logic                    cfg_valid   = 1'b0;
    logic [CAP_W-1:0]        cfg_data    = '0;

    // Block outputs
    logic                    busy;
    logic                    done;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
    logic                    cfg_ready;

    // Request and expectation queues
    cache_req_t  pending_reqs[$];
    cache_resp_t expected_resps[$];
    cache_req_t  cur_req;
    bit          req_open = 1'b0;
    int unsigned gap_left = 0;
    int          err_count = 0;
    int unsigned cyc_count = 0;

    // Behavioural copy of the store
    logic [KEY_W-1:0] slot_key[ENTRIES];
    logic [VAL_W-1:0] slot_val[ENTRIES];
    bit               slot_live[ENTRIES];
    int unsigned      slot_age[ENTRIES];
    int unsigned      live_n = 0;
    logic [CAP_W-1:0] cap_reg = CAP_RESET;

    lru_key_value_cache #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .lookup_key (lookup_key),
        .store_value(store_value),
        .done       (done),
        .found      (found),
        .read_value (read_value),
        .evicted    (evicted),
        .evicted_key(evicted_key),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // Free-running clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Make a slot most recent; age the live slots that were more recent than limit
    function automatic void make_recent(int slot, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_live[i] && i != slot && slot_age[i] < limit)
                slot_age[i]++;
        end
        slot_age[slot] = 0;
    endfunction

    // Apply one request to the store copy and return the result it should give
    function automatic cache_resp_t apply_request(cache_req_t r);
        cache_resp_t res;
        int          hit;
        int          slot;
        int unsigned best;
        int unsigned eff_cap;
        res = '{found: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && slot_live[i] && slot_key[i] == r.key)
                hit = i;
        end
        if (hit >= 0)
        begin
            res.found = 1'b1;
            if (r.op == CMD_GET)
                res.read_value = slot_val[hit];
            else
                slot_val[hit] = r.value;
            make_recent(hit, slot_age[hit]);
        end
        else if (r.op == CMD_PUT)
        begin
            slot = -1;
            best = 0;
            eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
            if (live_n >= eff_cap)
            begin
                // Evict the oldest live slot, lowest index on a tie
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_live[i] && (slot < 0 || slot_age[i] > best))
                    begin
                        slot = i;
                        best = slot_age[i];
                    end
                end
                if (slot >= 0)
                begin
                    res.evicted     = 1'b1;
                    res.evicted_key = slot_key[slot];
                    slot_live[slot] = 1'b0;
                    live_n--;
                end
            end
            if (slot < 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot < 0 && !slot_live[i])
                        slot = i;
                end
            end
            if (slot >= 0)
            begin
                slot_key[slot]  = r.key;
                slot_val[slot]  = r.value;
                slot_live[slot] = 1'b1;
                make_recent(slot, 32'hFFFF_FFFF);
                live_n++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Accept a request and record its expected result
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_resps.push_back(apply_request(cur_req));
            req_open = 1'b0;
            gap_left = cur_req.gap;
        end
    end

    // Drive the next request at the falling edge; hold it until accepted.
    // Idle cycles are counted only once the block has gone idle again.
    always @(negedge clk)
    begin
        if (!req_open)
        begin
            if (gap_left > 0)
            begin
                if (!busy)
                    gap_left--;
                start <= 1'b0;
            end
            else if (rst_n && pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                req_open = 1'b1;
                start       <= 1'b1;
                cmd         <= cur_req.op;
                lookup_key  <= cur_req.key;
                store_value <= cur_req.value;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        cache_resp_t want;
        if (rst_n && done)
        begin
            if (expected_resps.size() == 0)
            begin
                report_mismatch("result with nothing expected", read_value, '0);
            end
            else
            begin
                want = expected_resps.pop_front();
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (evicted !== want.evicted)
                    report_mismatch("evicted", evicted, want.evicted);
                if (evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", evicted_key, want.evicted_key);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cyc_count++;
        if (cyc_count > CYC_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_req(cmd_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        cache_req_t r;
        r.op    = op;
        r.key   = key;
        r.value = value;
        r.gap   = $urandom_range(0, 13);
        pending_reqs.push_back(r);
    endtask

    // Wait until every queued request has been answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_open || expected_resps.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: keys mostly from a pool a little larger than the capacity
    task automatic run_random_phase(logic [CAP_W-1:0] cap);
        logic [KEY_W-1:0] key_pool[$];
        cache_req_t       r;
        int unsigned      eff_cap;
        int unsigned      pool_n;
        write_capacity(cap);
        eff_cap = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
        pool_n  = eff_cap + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       key_pool.push_back(32'h8000_0000);
                1:       key_pool.push_back(32'h7FFF_FFFF);
                2:       key_pool.push_back(32'h0000_0000);
                3:       key_pool.push_back(32'hFFFF_FFFF);
                default: key_pool.push_back($urandom);
            endcase
        end
        for (int k = 0; k < PHASE_LEN; k++)
        begin
            r.op    = cmd_t'($urandom_range(0, 1));
            r.key   = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_n - 1)];
            r.value = $urandom;
            // Alternate back-to-back stretches with idle gaps
            r.gap   = ((k / 20) % 3 == 0) ? 0 : $urandom_range(0, 13);
            pending_reqs.push_back(r);
        end
        wait_drained();
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps[10];
        caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd16, 5'd2, 5'd5, 5'd12};
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end

        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: miss on empty store, extreme keys and values, update, fill, evict
        queue_req(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_req(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
        queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(CMD_GET, 32'h0000_0001, 32'h0000_0000);
        for (int i = 0; i < 12; i++)
            queue_req(CMD_PUT, 100 + i, $urandom);
        queue_req(CMD_PUT, 32'h0000_00C8, 32'hA5A5_5A5A);
        queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        wait_drained();

        // Random phases over a spread of capacities, lowered below the live count at times
        foreach (caps[p])
            run_random_phase(caps[p]);

        repeat (30) @(posedge clk);
        if (expected_resps.size() != 0)
            report_mismatch("results never arrived", expected_resps.size(), 0);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lru_key_value_cache.sv
bench/tb.sv
